// File: src/pci_pkg.sv
package pci_pkg;

	// register indexes of the configuration port
	localparam logic [2:0] REG_POINT_COUNT = 3'd0;
	localparam logic [2:0] REG_POINTS_LO   = 3'd1;
	localparam logic [2:0] REG_POINTS_HI   = 3'd2;
	localparam logic [2:0] REG_COLORS_LO   = 3'd3;
	localparam logic [2:0] REG_COLORS_HI   = 3'd4;

	localparam int TABLE_POINTS = 4;
	localparam int DEF_MAX_POINTS = 4;
	localparam int QUEUE_DEPTH = 4;

	// datapath widths
	localparam int NUM_W   = 33;
	localparam int DIV_W   = 49;
	localparam int REM_W   = 34;
	localparam int RATIO_W = 28;
	localparam int PROD_W  = 37;
	localparam int RATIO_LIM = 1 << 26;

	localparam logic [63:0] POINTS_LO_RST = 64'h0001_0000_0000_0000;

	typedef struct packed {
		logic [2:0]                         point_count;
		logic [TABLE_POINTS-1:0][31:0]      points;
		logic [TABLE_POINTS-1:0][31:0]      colors;
	} cfg_t;

	// classified word handed from front to back
	typedef struct packed {
		logic              is_div;
		logic [31:0]       color;
		logic [NUM_W-1:0]  num;
		logic [NUM_W-1:0]  den;
		logic [31:0]       cmin;
		logic [31:0]       cmax;
	} entry_t;

	// one stage of the divider pipeline
	typedef struct packed {
		logic              is_div;
		logic [31:0]       color;
		logic              neg;
		logic [NUM_W-1:0]  den;
		logic [REM_W-1:0]  rem;
		logic [DIV_W-1:0]  nq;
		logic [31:0]       cmin;
		logic [31:0]       cmax;
	} div_t;

endpackage

// File: src/piecewise_color_interpolator_core.sv
// path: a word taken on start passes the front, the queue, the divider and the blend stages to done
// throughput: one word per cycle while busy is low, set by the 49-stage pipelined divider
// busy rises only if the front queue nears full; with no result stall it stays low
// the receiver cannot stall: done is a one-cycle strobe
// reset: asynchronous active low, restores register defaults and empties the pipes
module piecewise_color_interpolator_core
	import pci_pkg::*;
#(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] sample_value,
	output logic               done,
	output logic [31:0]        blended_color,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	logic [2:0]  point_count_q;
	logic [63:0] points_lo_q, points_hi_q, colors_lo_q, colors_hi_q;
	cfg_t cfg;

	logic   push, empty, almost_full, accept;
	entry_t push_word, head;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= 3'd2;
			points_lo_q <= POINTS_LO_RST;
			points_hi_q <= '0;
			colors_lo_q <= '0;
			colors_hi_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POINT_COUNT: point_count_q <= cfg_data[2:0];
				REG_POINTS_LO:   points_lo_q <= cfg_data;
				REG_POINTS_HI:   points_hi_q <= cfg_data;
				REG_COLORS_LO:   colors_lo_q <= cfg_data;
				REG_COLORS_HI:   colors_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.point_count = point_count_q;
	assign cfg.points = {points_hi_q, points_lo_q};
	assign cfg.colors = {colors_hi_q, colors_lo_q};

	assign busy = almost_full;
	assign accept = start && !busy;

	pci_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (sample_value),
		.cfg    (cfg),
		.push   (push),
		.entry  (push_word)
	);

	pci_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_data   (push_word),
		.pop         (!empty),
		.head        (head),
		.empty       (empty),
		.almost_full (almost_full)
	);

	pci_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!empty),
		.in_word   (head),
		.out_valid (done),
		.out_color (blended_color)
	);

endmodule

// File: src/pci_front.sv
module pci_front
	import pci_pkg::*;
#(
	parameter int MAX_POINTS = DEF_MAX_POINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic signed [31:0] sample,
	input  cfg_t               cfg,
	output logic               push,
	output entry_t             entry
);

	logic [2:0]  n_eff;
	logic [1:0]  seg;
	logic        found;

	logic               v_s1;
	logic signed [31:0] smp_s1, pmin_s1, pmax_s1;
	logic [31:0]        cmin_s1, cmax_s1;

	logic   v_s2;
	entry_t ent_s2;
	entry_t ent_c;

	// segment search over the inner breakpoints
	always_comb begin
		n_eff = cfg.point_count;
		if (n_eff < 3'd2) n_eff = 3'd2;
		if (n_eff > 3'(MAX_POINTS)) n_eff = 3'(MAX_POINTS);
		seg = 2'd0;
		found = 1'b0;
		for (int k = 1; k < MAX_POINTS - 1; k++) begin
			if (!found && (3'(k + 1) < n_eff)) begin
				if ($signed(cfg.points[k]) >= sample) found = 1'b1;
				else seg = 2'(k);
			end
		end
	end

	// stage 1 and stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// stage 1 segment endpoints
	always_ff @(posedge clk) begin
		smp_s1  <= sample;
		pmin_s1 <= $signed(cfg.points[seg]);
		pmax_s1 <= $signed(cfg.points[2'(seg + 2'd1)]);
		cmin_s1 <= cfg.colors[seg];
		cmax_s1 <= cfg.colors[2'(seg + 2'd1)];
	end

	// classify: plain color, step or divide
	always_comb begin
		ent_c.cmin = cmin_s1;
		ent_c.cmax = cmax_s1;
		ent_c.num = NUM_W'($signed({smp_s1[31], smp_s1}) - $signed({pmin_s1[31], pmin_s1}));
		ent_c.den = NUM_W'($signed({pmax_s1[31], pmax_s1}) - $signed({pmin_s1[31], pmin_s1}));
		ent_c.is_div = 1'b0;
		if (cmin_s1 == cmax_s1) ent_c.color = cmin_s1;
		else if (pmin_s1 == pmax_s1) ent_c.color = (smp_s1 <= pmin_s1) ? cmin_s1 : cmax_s1;
		else begin
			ent_c.color = cmin_s1;
			ent_c.is_div = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		ent_s2 <= ent_c;
	end

	assign push  = v_s2;
	assign entry = ent_s2;

endmodule

// File: src/pci_queue.sv
module pci_queue
	import pci_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	input  logic   pop,
	output entry_t head,
	output logic   empty,
	output logic   almost_full
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	entry_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= PTR_W'(wr_q + 1'b1);
			if (pop) rd_q <= PTR_W'(rd_q + 1'b1);
			if (push && !pop) count_q <= (PTR_W+1)'(count_q + 1'b1);
			else if (pop && !push) count_q <= (PTR_W+1)'(count_q - 1'b1);
		end
	end

	assign head = mem_q[rd_q];
	assign empty = (count_q == '0);
	// two words may still be in flight in the front
	assign almost_full = (count_q >= (PTR_W+1)'(QUEUE_DEPTH - 2));

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && count_q == (PTR_W+1)'(QUEUE_DEPTH)))
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue underflow");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == (PTR_W+1)'($past(count_q) + 1'b1))
		else $error("queue count mismatch");

endmodule

// File: src/pci_back.sv
module pci_back
	import pci_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  entry_t      in_word,
	output logic        out_valid,
	output logic [31:0] out_color
);

	localparam int STEPS = DIV_W;

	div_t st_q [STEPS+1];
	logic st_v_q [STEPS+1];

	logic                      r_v_s1, m_v_s2, o_v_q;
	logic signed [RATIO_W-1:0] ratio_s1;
	logic                      is_div_s1, is_div_s2;
	logic [31:0]               color_s1, cmin_s1, cmax_s1, color_s2, cmin_s2;
	logic signed [PROD_W-1:0]  prod_s2 [4];
	logic [31:0]               blend_c, color_q;

	logic [NUM_W-1:0] num_mag, den_mag;
	logic [RATIO_W-1:0] mag_c;

	function automatic div_t div_step(input div_t x);
		div_t y;
		logic [REM_W-1:0] t;
		logic qb;
		y = x;
		t = {x.rem[REM_W-2:0], x.nq[DIV_W-1]};
		qb = (t >= {1'b0, x.den});
		y.rem = qb ? REM_W'(t - {1'b0, x.den}) : t;
		y.nq = {x.nq[DIV_W-2:0], qb};
		return y;
	endfunction

	// magnitudes for the divider
	always_comb begin
		num_mag = in_word.num[NUM_W-1] ? NUM_W'(-in_word.num) : in_word.num;
		den_mag = in_word.den[NUM_W-1] ? NUM_W'(-in_word.den) : in_word.den;
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STEPS; k++) st_v_q[k] <= 1'b0;
			r_v_s1 <= 1'b0;
			m_v_s2 <= 1'b0;
			o_v_q <= 1'b0;
		end else begin
			st_v_q[0] <= in_valid;
			for (int k = 0; k < STEPS; k++) st_v_q[k+1] <= st_v_q[k];
			r_v_s1 <= st_v_q[STEPS];
			m_v_s2 <= r_v_s1;
			o_v_q <= m_v_s2;
		end
	end

	// restoring divider, one quotient bit per stage
	always_ff @(posedge clk) begin
		st_q[0].is_div <= in_word.is_div;
		st_q[0].color  <= in_word.color;
		st_q[0].neg    <= in_word.num[NUM_W-1] ^ in_word.den[NUM_W-1];
		st_q[0].den    <= den_mag;
		st_q[0].rem    <= '0;
		st_q[0].nq     <= {num_mag[DIV_W-17:0], 16'b0};
		st_q[0].cmin   <= in_word.cmin;
		st_q[0].cmax   <= in_word.cmax;
		for (int k = 0; k < STEPS; k++) st_q[k+1] <= div_step(st_q[k]);
	end

	// clamp ratio: beyond the limit the magnitude is held at the limit
	always_comb begin
		mag_c = (st_q[STEPS].nq >= DIV_W'(RATIO_LIM)) ? RATIO_W'(RATIO_LIM)
			: st_q[STEPS].nq[RATIO_W-1:0];
	end

	always_ff @(posedge clk) begin
		ratio_s1  <= st_q[STEPS].neg ? $signed(RATIO_W'(-mag_c)) : $signed(mag_c);
		is_div_s1 <= st_q[STEPS].is_div;
		color_s1  <= st_q[STEPS].color;
		cmin_s1   <= st_q[STEPS].cmin;
		cmax_s1   <= st_q[STEPS].cmax;
	end

	// per channel product ratio * (cmax - cmin)
	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 4; ch++) begin
			prod_s2[ch] <= ratio_s1 * ($signed({1'b0, cmax_s1[8*ch +: 8]})
				- $signed({1'b0, cmin_s1[8*ch +: 8]}));
		end
		is_div_s2 <= is_div_s1;
		color_s2  <= color_s1;
		cmin_s2   <= cmin_s1;
	end

	// add base, truncate and saturate
	always_comb begin
		logic signed [PROD_W:0] acc;
		blend_c = '0;
		for (int ch = 0; ch < 4; ch++) begin
			acc = $signed({prod_s2[ch][PROD_W-1], prod_s2[ch]})
				+ $signed({(PROD_W-23)'(0), cmin_s2[8*ch +: 8], 16'b0});
			if (acc[PROD_W]) blend_c[8*ch +: 8] = 8'd0;
			else if (|acc[PROD_W-1:24]) blend_c[8*ch +: 8] = 8'hff;
			else blend_c[8*ch +: 8] = acc[23:16];
		end
	end

	always_ff @(posedge clk) begin
		color_q <= is_div_s2 ? blend_c : color_s2;
	end

	assign out_valid = o_v_q;
	assign out_color = color_q;

endmodule
